>>> sv/clnps_pkg.sv
`timescale 1ns / 1ps

package clnps_pkg;

  // Command codes carried on the slave-side tuser.
  typedef enum logic [1:0] {
    CMD_BYTE      = 2'd0,
    CMD_NIBBLE    = 2'd1,
    CMD_BACKLIGHT = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_RS        = 3'd0,
    REG_ENABLE    = 3'd1,
    REG_D4        = 3'd2,
    REG_D5        = 3'd3,
    REG_D6        = 3'd4,
    REG_D7        = 3'd5,
    REG_BACKLIGHT = 3'd6
  } reg_idx_e;

  localparam int unsigned NumRegs     = 7;
  localparam int unsigned RegWidth    = 3;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned InDataWidth = 16;
  localparam int unsigned InUserWidth = 2;
  localparam int unsigned OutDataWidth = 16;
  localparam int unsigned WaitWidth   = 7;

  localparam logic [RegWidth-1:0] RegReset [NumRegs] = '{
    3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1
  };

  // Step numbering of a byte: RS update, high nibble, low nibble.
  localparam logic [3:0] StepRs      = 4'd0;
  localparam logic [3:0] StepHighNib = 4'd1;
  localparam logic [3:0] StepLowNib  = 4'd8;
  localparam logic [3:0] StepLast    = 4'd14;

  // Sub-steps within one nibble.
  localparam logic [2:0] SubEnLow1  = 3'd4;
  localparam logic [2:0] SubEnHigh  = 3'd5;
  localparam logic [2:0] SubEnLow2  = 3'd6;

  localparam logic [WaitWidth-1:0] WaitNone   = 7'd0;
  localparam logic [WaitWidth-1:0] WaitStrobe = 7'd1;
  localparam logic [WaitWidth-1:0] WaitSettle = 7'd100;

  // One classified command waiting for the sequencer.
  typedef struct packed {
    logic       is_bl;   // single backlight update
    logic [3:0] start;   // first step of the sequence
    logic [7:0] value;   // byte or nibble to send
    logic       level;   // RS level or backlight level
  } job_t;

endpackage

>>> sv/clnps_front.sv
`timescale 1ns / 1ps

module clnps_front (
  input  logic                                s_valid_i,
  input  logic [clnps_pkg::InUserWidth-1:0]   s_user_i,
  input  logic [clnps_pkg::InDataWidth-1:0]   s_data_i,
  output logic                                s_ready_o,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output clnps_pkg::job_t                     q_job_o
);
  import clnps_pkg::*;

  logic keep;

  assign s_ready_o = !q_full_i;

  // Classify the command; the unused code is swallowed without a job.
  always_comb begin
    keep          = 1'b1;
    q_job_o.is_bl = 1'b0;
    q_job_o.start = StepRs;
    q_job_o.value = s_data_i[7:0];
    q_job_o.level = s_data_i[8];
    case (cmd_e'(s_user_i))
      CMD_BYTE: begin
        q_job_o.start = StepRs;
      end
      CMD_NIBBLE: begin
        q_job_o.start = StepLowNib;
      end
      CMD_BACKLIGHT: begin
        q_job_o.is_bl = 1'b1;
        q_job_o.level = s_data_i[9];
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push_o = s_valid_i && !q_full_i && keep;

endmodule

>>> sv/clnps_queue.sv
`timescale 1ns / 1ps

module clnps_queue #(
  parameter int unsigned Depth = clnps_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  clnps_pkg::job_t push_job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output clnps_pkg::job_t head_job_o
);
  import clnps_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

>>> sv/clnps_back.sv
`timescale 1ns / 1ps

module clnps_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_idx_i,
  input  logic [clnps_pkg::RegWidth-1:0]       cfg_data_i,
  input  logic                                 head_valid_i,
  input  clnps_pkg::job_t                      head_job_i,
  output logic                                 pop_o,
  output logic                                 m_valid_o,
  input  logic                                 m_ready_i,
  output logic [clnps_pkg::OutDataWidth-1:0]   m_data_o,
  output logic                                 m_last_o
);
  import clnps_pkg::*;

  logic [RegWidth-1:0]  pos_q [NumRegs];
  logic [7:0]           image_q, image_d;
  logic [3:0]           step_q, step_d;
  logic                 first_q, first_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_image_q;
  logic [WaitWidth-1:0] out_wait_q;
  logic                 out_last_q;

  logic                 advance;
  logic [3:0]           cur;
  logic                 high;
  logic [3:0]           nib;
  logic [2:0]           sub;
  logic [RegWidth-1:0]  pos;
  logic                 lvl;
  logic [WaitWidth-1:0] wait_us;
  logic                 last;

  assign advance = head_valid_i && (!out_valid_q || m_ready_i);
  assign cur     = first_q ? head_job_i.start : step_q;
  assign high    = (cur < StepLowNib);
  assign nib     = high ? head_job_i.value[7:4] : head_job_i.value[3:0];
  assign sub     = high ? 3'(cur - StepHighNib) : 3'(cur - StepLowNib);

  always_comb begin
    pos     = pos_q[REG_ENABLE];
    lvl     = 1'b0;
    wait_us = WaitNone;
    last    = 1'b0;
    if (head_job_i.is_bl) begin
      pos  = pos_q[REG_BACKLIGHT];
      lvl  = head_job_i.level;
      last = 1'b1;
    end else if (cur == StepRs) begin
      pos = pos_q[REG_RS];
      lvl = head_job_i.level;
    end else begin
      last = (cur == StepLast);
      case (sub)
        3'd0: begin
          pos = pos_q[REG_D4];
          lvl = nib[0];
        end
        3'd1: begin
          pos = pos_q[REG_D5];
          lvl = nib[1];
        end
        3'd2: begin
          pos = pos_q[REG_D6];
          lvl = nib[2];
        end
        3'd3: begin
          pos = pos_q[REG_D7];
          lvl = nib[3];
        end
        SubEnLow1: begin
          wait_us = WaitStrobe;
        end
        SubEnHigh: begin
          lvl     = 1'b1;
          wait_us = WaitStrobe;
        end
        SubEnLow2: begin
          wait_us = WaitSettle;
        end
        default: begin
          wait_us = WaitNone;
        end
      endcase
    end
  end

  always_comb begin
    image_d      = image_q;
    image_d[pos] = lvl;
  end

  assign pop_o = advance && last;

  always_comb begin
    step_d      = step_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !m_ready_i;
    if (advance) begin
      out_valid_d = 1'b1;
      first_d     = last;
      step_d      = cur + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        pos_q[i] <= RegReset[i];
      end
      image_q     <= '0;
      step_q      <= StepRs;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i < 3'(NumRegs))) begin
        pos_q[cfg_idx_i] <= cfg_data_i;
      end
      if (advance) begin
        image_q <= image_d;
      end
      step_q      <= step_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_image_q <= image_d;
      out_wait_q  <= wait_us;
      out_last_q  <= last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {1'b0, out_wait_q, out_image_q};
  assign m_last_o  = out_last_q;

endmodule

>>> sv/char_lcd_nibble_pin_sequencer.sv
`timescale 1ns / 1ps

// Character LCD 4-bit pin sequencer.
// Commands arrive on the slave stream: tuser carries the command code and tdata
// the byte, the RS level and the backlight level. Each command becomes a run of
// eight-bit pin images on the master stream, each with its hold time in
// microseconds, tlast marking the final image of the command. A byte gives 15
// words, a nibble 7, a backlight change 1; the unused code gives none.
// The front classifies a command in the cycle it is accepted and pushes it into
// a two-entry queue; the back steps through the images, one per cycle while the
// receiver takes them, through a single output register. An accepted command
// is written into the queue, and its first image is registered in the output
// register before it is presented. Back-to-back commands stream with no gap
// between their images.
// When the receiver stalls the output word holds, the sequencer pauses and the
// queue fills; tready falls only when the queue is full. Reset clears the pin
// image to zero and loads the default pin positions. The user must write the
// position registers through cfg_we_i only while the block is idle; the block itself does not enforce this.
module char_lcd_nibble_pin_sequencer #(
  parameter int unsigned QueueDepth = clnps_pkg::QueueDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Position register write port.
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_idx_i,
  input  logic [clnps_pkg::RegWidth-1:0]       cfg_data_i,
  // Command stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: value [7:0], rs_mode [8], backlight_on [9], zero fill [15:10].
  input  logic [clnps_pkg::InDataWidth-1:0]    s_axis_tdata,
  // tuser: cmd [1:0].
  input  logic [clnps_pkg::InUserWidth-1:0]    s_axis_tuser,
  // Pin image stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: pin_image [7:0], wait_us [14:8], zero fill [15].
  output logic [clnps_pkg::OutDataWidth-1:0]   m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import clnps_pkg::*;

  job_t push_job;
  job_t head_job;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  // The front decodes the command into a job for the sequencer.
  clnps_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_user_i  (s_axis_tuser),
    .s_data_i  (s_axis_tdata),
    .s_ready_o (s_axis_tready),
    .q_full_i  (full),
    .q_push_o  (push),
    .q_job_o   (push_job)
  );

  // The queue lets the front keep accepting while the back is stalled.
  clnps_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  // The back owns the pin image and the position registers.
  clnps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata),
    .m_last_o     (m_axis_tlast)
  );

endmodule

>>> tb/char_lcd_nibble_pin_sequencer_test.sv
`timescale 1ns / 1ps

module char_lcd_nibble_pin_sequencer_test;
  import clnps_pkg::*;

  // The one command code that the block has to swallow without a word.
  localparam logic [1:0] CmdUnused = 2'd3;
  // Cycles allowed after the last expected word before a position write.
  // The first image leaves through the queue and the output register, so this
  // is ample for the back to fall idle.
  localparam int unsigned SettleCycles = 8;
  // Cycles with no word moving on either stream before the run is abandoned.
  localparam int unsigned QuietLimit = 2000;

  typedef logic [RegWidth-1:0] pin_map_t [NumRegs];

  // Scoreboard: a private copy of the pin image and of the pin positions,
  // and the words that the block still owes, oldest first.
  class pin_image_scoreboard;
    typedef struct packed {
      logic [7:0]           image;
      logic [WaitWidth-1:0] hold_us;
      logic                 is_last;
    } pin_word_t;

    logic [RegWidth-1:0] pos [NumRegs];
    logic [7:0]          image;
    pin_word_t           owed [$];
    int unsigned         errors;

    function new();
      image  = '0;
      errors = 0;
      for (int i = 0; i < NumRegs; i++) pos[i] = RegReset[i];
    endfunction

    function void set_position(reg_idx_e idx, logic [RegWidth-1:0] bit_pos);
      pos[idx] = bit_pos;
    endfunction

    // One single-bit update of the image, owed as one word.
    function void drive_pin(logic [RegWidth-1:0] bit_pos, logic level,
                            logic [WaitWidth-1:0] hold);
      image[bit_pos] = level;
      owed.push_back('{image, hold, 1'b0});
    endfunction

    function void push_nibble(logic [3:0] nib);
      drive_pin(pos[REG_D4], nib[0], WaitNone);
      drive_pin(pos[REG_D5], nib[1], WaitNone);
      drive_pin(pos[REG_D6], nib[2], WaitNone);
      drive_pin(pos[REG_D7], nib[3], WaitNone);
      drive_pin(pos[REG_ENABLE], 1'b0, WaitStrobe);
      drive_pin(pos[REG_ENABLE], 1'b1, WaitStrobe);
      drive_pin(pos[REG_ENABLE], 1'b0, WaitSettle);
    endfunction

    // Called for every command the block accepts.
    function void note_command(logic [1:0] cmd, logic [7:0] value, logic rs_mode,
                               logic bl_on);
      pin_word_t tail;
      case (cmd)
        CMD_BYTE: begin
          drive_pin(pos[REG_RS], rs_mode, WaitNone);
          push_nibble(value[7:4]);
          push_nibble(value[3:0]);
        end
        CMD_NIBBLE: begin
          push_nibble(value[3:0]);
        end
        CMD_BACKLIGHT: begin
          drive_pin(pos[REG_BACKLIGHT], bl_on, WaitNone);
        end
        default: begin
          return;
        end
      endcase
      tail = owed.pop_back();
      tail.is_last = 1'b1;
      owed.push_back(tail);
    endfunction

    // Called for every word the block hands over.
    function void check_word(logic [OutDataWidth-1:0] tdata, logic tlast);
      pin_word_t want;
      if (owed.size() == 0) begin
        $error("unexpected pin word: tdata %h tlast %b", tdata, tlast);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (tdata[7:0] !== want.image) begin
        $error("pin_image: expected %h, actual %h", want.image, tdata[7:0]);
        errors++;
      end
      if (tdata[14:8] !== want.hold_us) begin
        $error("wait_us: expected %0d, actual %0d", want.hold_us, tdata[14:8]);
        errors++;
      end
      if (tlast !== want.is_last) begin
        $error("last: expected %b, actual %b", want.is_last, tlast);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [2:0]                cfg_idx_i;
  logic [RegWidth-1:0]       cfg_data_i;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [InDataWidth-1:0]    s_axis_tdata;
  logic [InUserWidth-1:0]    s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [OutDataWidth-1:0]   m_axis_tdata;
  logic                      m_axis_tlast;

  pin_image_scoreboard board;
  // Percentage of cycles in which the command side and the pin side idle.
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned quiet_cycles;

  char_lcd_nibble_pin_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Pin side: every word taken at an edge is checked against the oldest
  // expectation, and tready is redrawn for the next edge. Values read here
  // are those from just before the edge, so the order of processes within
  // the step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_word(m_axis_tdata, m_axis_tlast);
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog: a run in which no word moves on either stream for too long
  // has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("char_lcd_nibble_pin_sequencer test failed");
        $finish;
      end
    end
  end

  // Offers one command and returns at the edge that accepts it. A random
  // gap may come first; without one, tvalid simply stays high from the
  // previous word, so it is never lowered and raised in the same step.
  task automatic send_command(input logic [1:0] cmd, input logic [7:0] value,
                              input logic rs_mode, input logic bl_on);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, bl_on, rs_mode, value};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_command(cmd, value, rs_mode, bl_on);
  endtask

  // Mostly byte commands, which carry the longest sequences, with nibble
  // and backlight commands mixed in and now and then the unused code as
  // noise. Only commands that produce words count towards the total.
  task automatic send_random(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    logic [1:0]  cmd;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 45) cmd = CMD_BYTE;
      else if (pick < 70) cmd = CMD_NIBBLE;
      else if (pick < 90) cmd = CMD_BACKLIGHT;
      else cmd = CmdUnused;
      send_command(cmd, 8'($urandom_range(255)), 1'($urandom), 1'($urandom));
      if (cmd != CmdUnused) sent++;
    end
  endtask

  // Stops offering commands, waits for every owed word, then waits out
  // SettleCycles for the back to fall idle.
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.owed.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all seven pin positions on consecutive edges. Only called while
  // the block is idle.
  task automatic load_positions(input pin_map_t map);
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_idx_e'(i);
      cfg_data_i <= map[i];
      @(posedge clk_i);
      board.set_position(reg_idx_e'(i), map[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    pin_map_t    map;
    logic [2:0]  order [8];
    logic [2:0]  swap;
    int unsigned j;

    board         = new();
    src_idle_pct  = 32;
    sink_idle_pct = 32;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed commands on the reset pin positions: extreme bytes on both
    // RS levels, nibbles whose upper value bits must be ignored, both
    // backlight levels with the unused fields set and clear, and the unused code.
    send_command(CMD_BYTE, 8'h00, 1'b0, 1'b0);
    send_command(CMD_BYTE, 8'hFF, 1'b1, 1'b1);
    send_command(CMD_BYTE, 8'hA5, 1'b0, 1'b1);
    send_command(CMD_BYTE, 8'h5A, 1'b1, 1'b0);
    send_command(CMD_NIBBLE, 8'h0F, 1'b1, 1'b1);
    send_command(CMD_NIBBLE, 8'hF0, 1'b0, 1'b0);
    send_command(CMD_NIBBLE, 8'hFA, 1'b1, 1'b0);
    send_command(CMD_BACKLIGHT, 8'hFF, 1'b1, 1'b1);
    send_command(CMD_BACKLIGHT, 8'h00, 1'b0, 1'b0);
    send_command(CMD_BACKLIGHT, 8'h55, 1'b1, 1'b1);
    send_command(CmdUnused, 8'hFF, 1'b1, 1'b1);
    send_command(CMD_BYTE, 8'h01, 1'b1, 1'b0);
    send_command(CmdUnused, 8'h00, 1'b0, 1'b0);
    send_command(CMD_NIBBLE, 8'h03, 1'b0, 1'b1);
    send_command(CMD_BYTE, 8'h80, 1'b0, 1'b1);
    drain_and_settle();

    // Every line on bit 0: all updates collide and the later one wins.
    for (int i = 0; i < NumRegs; i++) map[i] = 3'd0;
    load_positions(map);
    send_random(25);
    drain_and_settle();

    // Every line on bit 7.
    for (int i = 0; i < NumRegs; i++) map[i] = 3'd7;
    load_positions(map);
    send_random(25);
    drain_and_settle();

    // Distinct positions in random order, streamed with no idling on either
    // side so that commands follow one another back to back.
    for (int i = 0; i < 8; i++) order[i] = 3'(i);
    for (int i = 7; i > 0; i--) begin
      j        = $urandom_range(i);
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    for (int i = 0; i < NumRegs; i++) map[i] = order[i];
    load_positions(map);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_random(35);
    drain_and_settle();
    src_idle_pct  = 32;
    sink_idle_pct = 32;

    // Random positions, shared ones likely among them.
    for (int i = 0; i < NumRegs; i++) map[i] = 3'($urandom_range(7));
    load_positions(map);
    send_random(25);
    drain_and_settle();

    // Back to the reset positions, with the pin side idling as usual while
    // the command side runs flat out, so the queue keeps filling.
    for (int i = 0; i < NumRegs; i++) map[i] = RegReset[i];
    load_positions(map);
    src_idle_pct = 0;
    send_random(25);
    drain_and_settle();

    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("char_lcd_nibble_pin_sequencer test passed");
    end else begin
      $display("char_lcd_nibble_pin_sequencer test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/clnps_pkg.sv
sv/clnps_front.sv
sv/clnps_queue.sv
sv/clnps_back.sv
sv/char_lcd_nibble_pin_sequencer.sv
tb/char_lcd_nibble_pin_sequencer_test.sv
